@@ rtl/epc_pkg.sv @@
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants of the Ethernet protocol classifier
// Payload structs, the record that passes from the parser to the counter
// stage, protocol and category codes, and small helper functions.
// ----------------------------------------------------------------------------
package epc_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } in_t;

    typedef struct packed {
        logic [2:0]  category;
        logic        was_ipv6;
        logic        filter_match;
        logic [15:0] transport_offset;
        logic [31:0] category_count;
        logic [31:0] ipv6_count;
        logic [31:0] total_count;
    } out_t;

    typedef struct packed {
        logic [2:0]  category;
        logic        was_ipv6;
        logic        filter_match;
        logic [15:0] transport_offset;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_CATS    = 6;

    localparam logic [2:0] CAT_OTHER  = 3'd0;
    localparam logic [2:0] CAT_TCP    = 3'd1;
    localparam logic [2:0] CAT_UDP    = 3'd2;
    localparam logic [2:0] CAT_ICMPV4 = 3'd3;
    localparam logic [2:0] CAT_ICMPV6 = 3'd4;
    localparam logic [2:0] CAT_IGMP   = 3'd5;

    localparam logic [2:0] FILT_ALL    = 3'd0;
    localparam logic [2:0] FILT_UDP    = 3'd1;
    localparam logic [2:0] FILT_TCP    = 3'd2;
    localparam logic [2:0] FILT_ICMP   = 3'd3;
    localparam logic [2:0] FILT_IPV6   = 3'd4;
    localparam logic [2:0] FILT_ICMPV6 = 3'd5;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_IGMP    = 8'd2;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_ROUTING = 8'd43;
    localparam logic [7:0] PROTO_FRAG    = 8'd44;
    localparam logic [7:0] PROTO_ICMPV6  = 8'd58;

    localparam int POS_ETYPE_HI  = 12;
    localparam int POS_ETYPE_LO  = 13;
    localparam int POS_V6_NEXT   = 20;
    localparam int POS_V4_PROTO  = 23;
    localparam int ETH_MIN_BYTES = 14;
    localparam int IPV4_MIN_BYTES = 34;
    localparam int IPV6_FIXED_END = 54;

    localparam logic [2:0] ADDR_FILTER_MODE = 3'd0;

    function automatic logic is_extension(input logic [7:0] h);
        return (h == PROTO_HOPOPT) || (h == PROTO_ROUTING) || (h == PROTO_FRAG);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ rtl/ethernet_ip_protocol_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// ethernet_ip_protocol_classifier_unit: Ethernet IPv4/IPv6 frame classifier
// Classes each frame as tcp, udp, icmpv4, icmpv6, igmp or other, walks IPv6
// extension headers and keeps saturating per-category traffic counters.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while in_stall is low, with no gaps
// between frames. The result of a frame passes through the two-entry record
// queue and then the counter stage output register on its way to the output
// channel. The input stalls only when the queue is full because the output
// is stalled.
// filter_mode sits at APB address 0.
module ethernet_ip_protocol_classifier_unit #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  epc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output epc_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [2:0]         filter_mode_reg;
    logic               push;
    logic               pop;
    epc_pkg::rec_t      push_rec;
    epc_pkg::rec_t      pop_rec;
    epc_pkg::q_status_t q_status;

    assign pready = 1'b1;
    assign prdata = (paddr == epc_pkg::ADDR_FILTER_MODE) ? {29'd0, filter_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filter_mode_reg <= epc_pkg::FILT_ALL;
        else if (psel && penable && pwrite && pready && paddr == epc_pkg::ADDR_FILTER_MODE)
            filter_mode_reg <= pwdata[2:0];
    end

    epc_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .filter_mode(filter_mode_reg),
        .q_status   (q_status),
        .push       (push),
        .push_rec   (push_rec)
    );

    epc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .pop_rec (pop_rec),
        .q_status(q_status)
    );

    epc_counters u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_rec  (pop_rec),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    a_total_ge_ipv6: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_count >= out_data.ipv6_count)
        else $error("ipv6 count exceeds total count");

    a_total_ge_cat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_count >= out_data.category_count)
        else $error("category count exceeds total count");

    a_offset_v6_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.was_ipv6) |-> out_data.transport_offset == 16'd0)
        else $error("transport offset on non-IPv6 frame");

    a_queue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> in_stall && !push)
        else $error("push into full queue");

endmodule

@@ rtl/epc_parser.sv @@
// ----------------------------------------------------------------------------
// epc_parser: per-byte frame parser and classifier
// Tracks the ethertype, IPv4 protocol and IPv6 extension header walk one byte
// per cycle unless stalled, and classes the frame on its final byte.
// ----------------------------------------------------------------------------
module epc_parser #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  epc_pkg::in_t      in_data,
    output logic              in_stall,
    input  logic [2:0]        filter_mode,
    input  epc_pkg::q_status_t q_status,
    output logic              push,
    output epc_pkg::rec_t     push_rec
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int BND_W = $clog2(MAX_FRAME_BYTES + 2049);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] FIXED_END_P = POS_W'(epc_pkg::IPV6_FIXED_END);
    localparam logic [BND_W-1:0] FIXED_END_B = BND_W'(epc_pkg::IPV6_FIXED_END);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      et_reg, et_next;
    logic [7:0]       proto_reg, proto_next;
    logic [7:0]       nh_reg, nh_next;
    logic [7:0]       staged_reg, staged_next;
    logic [POS_W-1:0] fo_reg, fo_next;
    logic [BND_W-1:0] bnd_reg, bnd_next;

    logic             accept;
    logic             frag;
    logic [BND_W-1:0] fo_b;
    logic [BND_W-1:0] pos_b;
    logic [BND_W-1:0] ext_len;
    logic [31:0]      fo_wide;
    logic [7:0]       b;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign push     = accept && in_data.frame_last;
    assign b        = in_data.frame_byte;
    assign frag     = (nh_reg == epc_pkg::PROTO_FRAG);
    assign fo_b     = BND_W'(fo_reg);
    assign pos_b    = BND_W'(pos_reg);
    assign ext_len  = BND_W'({({1'b0, b} + 9'd1), 3'b000});

    always_comb
    begin
        pos_next    = pos_reg;
        et_next     = et_reg;
        proto_next  = proto_reg;
        nh_next     = nh_reg;
        staged_next = staged_reg;
        fo_next     = fo_reg;
        bnd_next    = bnd_reg;
        if (pos_reg < MAX_POS)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(epc_pkg::POS_ETYPE_HI))
                et_next[15:8] = b;
            if (pos_reg == POS_W'(epc_pkg::POS_ETYPE_LO))
                et_next[7:0] = b;
            if (pos_reg == POS_W'(epc_pkg::POS_V6_NEXT))
                nh_next = b;
            if (pos_reg == POS_W'(epc_pkg::POS_V4_PROTO))
                proto_next = b;
            if (pos_reg >= FIXED_END_P && epc_pkg::is_extension(nh_reg))
            begin
                priority if (pos_reg == fo_reg)
                begin
                    staged_next = b;
                    if (frag)
                        bnd_next = fo_b + BND_W'(8);
                end
                else if (pos_b == fo_b + BND_W'(1) && !frag)
                begin
                    bnd_next = fo_b + ext_len;
                end
                else if (bnd_reg > fo_b + BND_W'(1) && pos_b + BND_W'(1) == bnd_reg)
                begin
                    fo_next = bnd_reg[POS_W-1:0];
                    nh_next = staged_reg;
                end
            end
        end
    end

    assign fo_wide = 32'(fo_next);

    always_comb
    begin
        push_rec.category         = epc_pkg::CAT_OTHER;
        push_rec.was_ipv6         = 1'b0;
        push_rec.filter_match     = (filter_mode == epc_pkg::FILT_ALL);
        push_rec.transport_offset = 16'd0;
        if (pos_next >= POS_W'(epc_pkg::ETH_MIN_BYTES) && et_next == epc_pkg::ETH_IPV6)
        begin
            push_rec.was_ipv6 = 1'b1;
            if (pos_next >= FIXED_END_P && !epc_pkg::is_extension(nh_next))
            begin
                if (nh_next == epc_pkg::PROTO_TCP)
                    push_rec.category = epc_pkg::CAT_TCP;
                else if (nh_next == epc_pkg::PROTO_UDP)
                    push_rec.category = epc_pkg::CAT_UDP;
                else if (nh_next == epc_pkg::PROTO_ICMPV6)
                    push_rec.category = epc_pkg::CAT_ICMPV6;
                push_rec.transport_offset = (fo_wide > 32'h0000_FFFF) ? 16'hFFFF
                                                                      : fo_wide[15:0];
                push_rec.filter_match = (filter_mode == epc_pkg::FILT_ALL)
                    || (filter_mode == epc_pkg::FILT_IPV6)
                    || (filter_mode == epc_pkg::FILT_TCP && nh_next == epc_pkg::PROTO_TCP)
                    || (filter_mode == epc_pkg::FILT_UDP && nh_next == epc_pkg::PROTO_UDP)
                    || ((filter_mode == epc_pkg::FILT_ICMP
                         || filter_mode == epc_pkg::FILT_ICMPV6)
                        && nh_next == epc_pkg::PROTO_ICMPV6);
            end
            else
            begin
                push_rec.filter_match = (filter_mode == epc_pkg::FILT_ALL)
                    || (filter_mode == epc_pkg::FILT_IPV6);
            end
        end
        else if (pos_next >= POS_W'(epc_pkg::IPV4_MIN_BYTES) && et_next == epc_pkg::ETH_IPV4)
        begin
            if (proto_next == epc_pkg::PROTO_ICMP)
                push_rec.category = epc_pkg::CAT_ICMPV4;
            else if (proto_next == epc_pkg::PROTO_IGMP)
                push_rec.category = epc_pkg::CAT_IGMP;
            else if (proto_next == epc_pkg::PROTO_TCP)
                push_rec.category = epc_pkg::CAT_TCP;
            else if (proto_next == epc_pkg::PROTO_UDP)
                push_rec.category = epc_pkg::CAT_UDP;
            push_rec.filter_match = (filter_mode == epc_pkg::FILT_ALL)
                || (filter_mode == epc_pkg::FILT_TCP && proto_next == epc_pkg::PROTO_TCP)
                || (filter_mode == epc_pkg::FILT_UDP && proto_next == epc_pkg::PROTO_UDP)
                || (filter_mode == epc_pkg::FILT_ICMP && proto_next == epc_pkg::PROTO_ICMP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            et_reg     <= '0;
            proto_reg  <= '0;
            nh_reg     <= '0;
            staged_reg <= '0;
            fo_reg     <= FIXED_END_P;
            bnd_reg    <= FIXED_END_B;
        end
        else if (accept)
        begin
            if (in_data.frame_last)
            begin
                // clear per-frame state after the final byte
                pos_reg    <= '0;
                et_reg     <= '0;
                proto_reg  <= '0;
                nh_reg     <= '0;
                staged_reg <= '0;
                fo_reg     <= FIXED_END_P;
                bnd_reg    <= FIXED_END_B;
            end
            else
            begin
                pos_reg    <= pos_next;
                et_reg     <= et_next;
                proto_reg  <= proto_next;
                nh_reg     <= nh_next;
                staged_reg <= staged_next;
                fo_reg     <= fo_next;
                bnd_reg    <= bnd_next;
            end
        end
    end

endmodule

@@ rtl/epc_queue.sv @@
// ----------------------------------------------------------------------------
// epc_queue: short record queue between parser and counter stage
// Holds classified frame records so that each side can stall on its own.
// ----------------------------------------------------------------------------
module epc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  epc_pkg::rec_t      push_rec,
    input  logic               pop,
    output epc_pkg::rec_t      pop_rec,
    output epc_pkg::q_status_t q_status
);

    localparam int DEPTH = epc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    epc_pkg::rec_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/epc_counters.sv @@
// ----------------------------------------------------------------------------
// epc_counters: saturating traffic counters and result register
// Pops one frame record per cycle unless the queue is empty or the output is
// stalled, updates category, IPv6 and total counts, and presents the result.
// ----------------------------------------------------------------------------
module epc_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  epc_pkg::q_status_t q_status,
    input  epc_pkg::rec_t      pop_rec,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output epc_pkg::out_t      out_data
);

    logic [31:0]   cat_cnt_reg [epc_pkg::NUM_CATS];
    logic [31:0]   v6_cnt_reg, v6_cnt_next;
    logic [31:0]   tot_cnt_reg, tot_cnt_next;
    logic [31:0]   cat_cnt_next;
    logic          out_valid_reg;
    epc_pkg::out_t out_reg;

    assign pop       = !q_status.empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cat_cnt_next = epc_pkg::sat_inc(cat_cnt_reg[pop_rec.category]);
    assign v6_cnt_next  = pop_rec.was_ipv6 ? epc_pkg::sat_inc(v6_cnt_reg) : v6_cnt_reg;
    assign tot_cnt_next = epc_pkg::sat_inc(tot_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epc_pkg::NUM_CATS; i++)
                cat_cnt_reg[i] <= '0;
            v6_cnt_reg    <= '0;
            tot_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cat_cnt_reg[pop_rec.category] <= cat_cnt_next;
                v6_cnt_reg    <= v6_cnt_next;
                tot_cnt_reg   <= tot_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.category         <= pop_rec.category;
            out_reg.was_ipv6         <= pop_rec.was_ipv6;
            out_reg.filter_match     <= pop_rec.filter_match;
            out_reg.transport_offset <= pop_rec.transport_offset;
            out_reg.category_count   <= cat_cnt_next;
            out_reg.ipv6_count       <= v6_cnt_next;
            out_reg.total_count      <= tot_cnt_next;
        end
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: Ethernet IPv4/IPv6 protocol classifier
// Streams Ethernet frames byte by byte into the classifier and checks every
// per-frame result against a cycle-free model of the parser, the IPv6
// extension-header walk, the filter rule and the saturating counters. Covers
// directed frames for every category and corner case, all filter settings,
// random traffic with idle bursts on both channels, and oversized frames.
// ----------------------------------------------------------------------------
module testbench;
    import epc_pkg::*;

    localparam int FRAME_LIMIT   = 65536;
    localparam int CNT_IPV6      = 6;
    localparam int CNT_ALL       = 7;
    localparam int RANDOM_BYTES  = 950;
    localparam int RANDOM_FRAMES = 48;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned parse_pos;
    logic [15:0] parse_etype;
    logic [7:0]  parse_v4_proto;
    logic [7:0]  walk_type;
    logic [7:0]  walk_staged;
    int unsigned walk_start;
    int unsigned walk_end;
    logic [31:0] traffic_count [8];
    logic [2:0]  filter_sel = FILT_ALL;

    out_t        verdicts_due [$];
    out_t        verdict_want;
    logic [7:0]  frame_buf [$];
    logic [7:0]  chain_hdrs [$];
    logic [7:0]  chain_units [$];

    int          errors = 0;
    int          frames_checked = 0;
    int          frames_sent = 0;
    int          bytes_sent = 0;
    bit          no_idle = 1'b0;
    int          hold_cnt = 0;

    ethernet_ip_protocol_classifier_unit #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit chain_header(input logic [7:0] h);
        return h == PROTO_HOPOPT || h == PROTO_ROUTING || h == PROTO_FRAG;
    endfunction

    function automatic void restart_frame();
        parse_pos      = 0;
        parse_etype    = '0;
        parse_v4_proto = '0;
        walk_type      = '0;
        walk_staged    = '0;
        walk_start     = IPV6_FIXED_END;
        walk_end       = IPV6_FIXED_END;
    endfunction

    function automatic void bump_count(input int idx);
        if (traffic_count[idx] != 32'hFFFF_FFFF)
        begin
            traffic_count[idx] = traffic_count[idx] + 32'd1;
        end
    endfunction

    function automatic void classify_byte(input logic [7:0] b, input logic last);
        bit         frag;
        bit         hit;
        out_t       v;
        logic [2:0] f;
        v = '0;
        f = filter_sel;
        if (parse_pos < FRAME_LIMIT)
        begin
            if (parse_pos == POS_ETYPE_HI) parse_etype[15:8] = b;
            if (parse_pos == POS_ETYPE_LO) parse_etype[7:0] = b;
            if (parse_pos == POS_V6_NEXT) walk_type = b;
            if (parse_pos == POS_V4_PROTO) parse_v4_proto = b;
            if (parse_pos >= IPV6_FIXED_END && chain_header(walk_type))
            begin
                frag = walk_type == PROTO_FRAG;
                if (parse_pos == walk_start)
                begin
                    walk_staged = b;
                    if (frag) walk_end = walk_start + 8;
                end
                else if (parse_pos == walk_start + 1 && !frag)
                begin
                    walk_end = walk_start + (int'(b) + 1) * 8;
                end
                else if (walk_end > walk_start + 1 && parse_pos + 1 == walk_end)
                begin
                    walk_start = walk_end;
                    walk_type  = walk_staged;
                end
            end
            parse_pos++;
        end
        if (!last) return;

        hit = f == FILT_ALL;
        v.category = CAT_OTHER;
        if (parse_pos >= ETH_MIN_BYTES && parse_etype == ETH_IPV6)
        begin
            v.was_ipv6 = 1'b1;
            if (parse_pos >= IPV6_FIXED_END && !chain_header(walk_type))
            begin
                case (walk_type)
                    PROTO_TCP:    v.category = CAT_TCP;
                    PROTO_UDP:    v.category = CAT_UDP;
                    PROTO_ICMPV6: v.category = CAT_ICMPV6;
                    default:      v.category = CAT_OTHER;
                endcase
                v.transport_offset = (walk_start > 65535) ? 16'hFFFF : walk_start[15:0];
                hit = f == FILT_ALL || f == FILT_IPV6
                    || (f == FILT_TCP && walk_type == PROTO_TCP)
                    || (f == FILT_UDP && walk_type == PROTO_UDP)
                    || ((f == FILT_ICMP || f == FILT_ICMPV6) && walk_type == PROTO_ICMPV6);
            end
            else
            begin
                hit = f == FILT_ALL || f == FILT_IPV6;
            end
        end
        else if (parse_pos >= IPV4_MIN_BYTES && parse_etype == ETH_IPV4)
        begin
            case (parse_v4_proto)
                PROTO_ICMP: v.category = CAT_ICMPV4;
                PROTO_IGMP: v.category = CAT_IGMP;
                PROTO_TCP:  v.category = CAT_TCP;
                PROTO_UDP:  v.category = CAT_UDP;
                default:    v.category = CAT_OTHER;
            endcase
            hit = f == FILT_ALL
                || (f == FILT_TCP && parse_v4_proto == PROTO_TCP)
                || (f == FILT_UDP && parse_v4_proto == PROTO_UDP)
                || (f == FILT_ICMP && parse_v4_proto == PROTO_ICMP);
        end
        v.filter_match = hit;
        bump_count(v.category);
        if (v.was_ipv6) bump_count(CNT_IPV6);
        bump_count(CNT_ALL);
        v.category_count = traffic_count[v.category];
        v.ipv6_count     = traffic_count[CNT_IPV6];
        v.total_count    = traffic_count[CNT_ALL];
        verdicts_due.push_back(v);
        frames_sent++;
        restart_frame();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                verdict_want = verdicts_due.pop_front();
                check_field("category", verdict_want.category, out_data.category);
                check_field("was_ipv6", verdict_want.was_ipv6, out_data.was_ipv6);
                check_field("filter_match", verdict_want.filter_match, out_data.filter_match);
                check_field("transport_offset", verdict_want.transport_offset,
                            out_data.transport_offset);
                check_field("category_count", verdict_want.category_count,
                            out_data.category_count);
                check_field("ipv6_count", verdict_want.ipv6_count, out_data.ipv6_count);
                check_field("total_count", verdict_want.total_count, out_data.total_count);
                frames_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cnt > 0)
            hold_cnt--;
        else if (!no_idle && $urandom_range(0, 5) == 0)
            hold_cnt = $urandom_range(1, 12);
        out_stall <= hold_cnt > 0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{frame_byte: b, frame_last: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        classify_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == n - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_filter(input logic [2:0] mode);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FILTER_MODE;
        pwdata  <= {29'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        filter_sel = mode;
    endtask

    function automatic void fill_frame(input int n, input int fixed);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(fixed < 0 ? 8'($urandom_range(0, 255)) : 8'(fixed));
    endfunction

    function automatic void put_byte(input int pos, input logic [7:0] val);
        if (pos < frame_buf.size()) frame_buf[pos] = val;
    endfunction

    function automatic void set_ether(input logic [15:0] et);
        put_byte(POS_ETYPE_HI, et[15:8]);
        put_byte(POS_ETYPE_LO, et[7:0]);
    endfunction

    function automatic void build_ipv4(input int n, input logic [7:0] proto);
        fill_frame(n, -1);
        set_ether(ETH_IPV4);
        put_byte(POS_V4_PROTO, proto);
    endfunction

    // chain_hdrs: extension types then the transport; chain_units: header lengths
    function automatic void build_ipv6(input int extra);
        int chain_end;
        int at;
        chain_end = IPV6_FIXED_END;
        for (int k = 0; k + 1 < chain_hdrs.size(); k++)
            chain_end += (chain_hdrs[k] == PROTO_FRAG) ? 8 : (int'(chain_units[k]) + 1) * 8;
        fill_frame((chain_end + extra < 1) ? 1 : chain_end + extra, -1);
        set_ether(ETH_IPV6);
        put_byte(POS_V6_NEXT, chain_hdrs[0]);
        at = IPV6_FIXED_END;
        for (int k = 0; k + 1 < chain_hdrs.size(); k++)
        begin
            put_byte(at, chain_hdrs[k + 1]);
            if (chain_hdrs[k] != PROTO_FRAG) put_byte(at + 1, chain_units[k]);
            at += (chain_hdrs[k] == PROTO_FRAG) ? 8 : (int'(chain_units[k]) + 1) * 8;
        end
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 2))
            0:       return PROTO_HOPOPT;
            1:       return PROTO_ROUTING;
            default: return PROTO_FRAG;
        endcase
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 6))
            0:       return PROTO_TCP;
            1:       return PROTO_UDP;
            2:       return PROTO_ICMPV6;
            3:       return PROTO_ICMP;
            4:       return PROTO_IGMP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_ipv6(input int extra);
        build_ipv6(extra);
        send_frame();
    endtask

    task automatic random_ipv6();
        int n_ext;
        int extra;
        chain_hdrs.delete();
        chain_units.delete();
        n_ext = $urandom_range(0, 3);
        repeat (n_ext)
        begin
            chain_hdrs.push_back(pick_ext());
            chain_units.push_back($urandom_range(0, 31) == 0 ? 8'($urandom_range(4, 255))
                                                              : 8'($urandom_range(0, 3)));
        end
        chain_hdrs.push_back(pick_proto());
        if ($urandom_range(0, 4) == 0)
            extra = -int'($urandom_range(1, 60));
        else
            extra = $urandom_range(0, 40);
        send_ipv6(extra);
    endtask

    task automatic random_frame();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 7)
        begin
            build_ipv4($urandom_range(30, 90), pick_proto());
            send_frame();
        end
        else if (kind < 15)
        begin
            random_ipv6();
        end
        else
        begin
            fill_frame(kind < 17 ? $urandom_range(1, 80) : $urandom_range(1, 53), -1);
            if (kind >= 17) set_ether($urandom_range(0, 1) ? ETH_IPV6 : ETH_IPV4);
            send_frame();
        end
    endtask

    task automatic category_sweep();
        build_ipv4(IPV4_MIN_BYTES, PROTO_TCP);
        send_frame();
        build_ipv4(60, PROTO_UDP);
        send_frame();
        build_ipv4(64, PROTO_ICMP);
        send_frame();
        build_ipv4(64, PROTO_IGMP);
        send_frame();
        build_ipv4(64, 8'hFF);
        send_frame();
        build_ipv4(IPV4_MIN_BYTES - 1, PROTO_TCP);
        send_frame();
        chain_units.delete();
        chain_hdrs = '{PROTO_TCP};
        send_ipv6(20);
        chain_hdrs = '{PROTO_UDP};
        send_ipv6(0);
        chain_hdrs = '{PROTO_ICMPV6};
        send_ipv6(8);
        chain_hdrs = '{8'hFF};
        send_ipv6(4);
        chain_hdrs = '{PROTO_TCP};
        send_ipv6(-1);
        chain_hdrs  = '{PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAG, PROTO_UDP};
        chain_units = '{8'd0, 8'd1, 8'd0};
        send_ipv6(8);
        send_ipv6(-3);
        fill_frame(ETH_MIN_BYTES - 1, -1);
        set_ether(ETH_IPV6);
        send_frame();
        fill_frame(60, -1);
        set_ether(16'h0806);
        send_frame();
    endtask

    task automatic test_directed_frames();
        fill_frame(1, 8'h00);
        send_frame();
        fill_frame(64, 8'hFF);
        send_frame();
        fill_frame(64, 8'h00);
        send_frame();
        category_sweep();
    endtask

    task automatic test_filter_modes();
        for (int m = 0; m < 8; m++)
        begin
            write_filter(3'(m));
            category_sweep();
            repeat (4) random_frame();
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int start_frames;
        start_bytes  = bytes_sent;
        start_frames = frames_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES
               || frames_sent - start_frames < RANDOM_FRAMES)
        begin
            if ($urandom_range(0, 11) == 0) write_filter(3'($urandom_range(0, 7)));
            random_frame();
        end
    endtask

    task automatic test_jumbo_frames();
        chain_hdrs.delete();
        chain_units.delete();
        repeat (31)
        begin
            chain_hdrs.push_back(PROTO_HOPOPT);
            chain_units.push_back(8'd255);
        end
        chain_hdrs.push_back(PROTO_HOPOPT);
        chain_units.push_back(8'd248);
        chain_hdrs.push_back(PROTO_TCP);
        // walk ends at 65534, frame runs past the byte limit
        write_filter(FILT_TCP);
        send_ipv6(FRAME_LIMIT + 64 - 65534);
        // last extension starts at 65534 and cannot end in the kept bytes
        chain_hdrs.pop_back();
        chain_hdrs.push_back(PROTO_HOPOPT);
        chain_units.push_back(8'd255);
        chain_hdrs.push_back(PROTO_UDP);
        write_filter(FILT_IPV6);
        send_ipv6(FRAME_LIMIT + 4 - (65534 + 2048));
    endtask

    task automatic test_steady_stream();
        write_filter(FILT_ALL);
        repeat (24) random_frame();
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++) traffic_count[i] = '0;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_filter_modes();
        test_random_traffic();
        no_idle = 1'b1;
        test_jumbo_frames();
        test_steady_stream();
        drain_results();
        $display("Checked %0d frame results from %0d bytes under filter settings 0 to 7,",
                 frames_checked, bytes_sent);
        $display("with IPv6 extension chains, truncated, short and oversized frames.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d results outstanding", verdicts_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
